// ----- rtl/core/bone_group_vertex_transform_defines.svh -----
// assertion macros for the bone group vertex transform checker
// no dependencies
`ifndef BONE_GROUP_VERTEX_TRANSFORM_DEFINES_SVH
`define BONE_GROUP_VERTEX_TRANSFORM_DEFINES_SVH

// same-cycle implication
`define BGVT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bgvt same-cycle check failed");

// next-cycle implication
`define BGVT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bgvt next-cycle check failed");

`endif

// ----- rtl/core/bgvt_pkg.sv -----
// shared types, constants and sine table for the bone group vertex transform
// no dependencies
package bgvt_pkg;

    localparam int SINE_TABLE_SIZE = 2048;
    localparam int QUARTER         = SINE_TABLE_SIZE / 4;
    localparam int TAB_STEP        = 8;
    localparam int TAB_LAST        = QUARTER / TAB_STEP;
    localparam int MUL_A_W         = 20;
    localparam int MUL_B_W         = 18;
    localparam int ACC_W           = MUL_A_W + MUL_B_W + 1;
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    typedef enum logic [2:0] {
        ACT_ACCUM      = 3'd0,
        ACT_SET_ORIGIN = 3'd1,
        ACT_TRANSLATE  = 3'd2,
        ACT_ROTATE     = 3'd3,
        ACT_SCALE      = 3'd4,
        ACT_ALPHA      = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_ROT,
        ST_SCALE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic en;
        logic load;
        logic sub;
    } mac_ctl_t;

    typedef logic [TAB_LAST:0][16:0] sin_tab_t;

    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // taylor series in q60, evaluated at elaboration
    function automatic logic [16:0] quarter_sine(input int r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic        neg;
        logic [63:0] sh;
        neg = 1'b1;
        if (r == 0)
            return 17'd0;
        if (r >= QUARTER)
            return 17'd65536;
        x    = (PI_Q60 / 64'(SINE_TABLE_SIZE / 2)) * 64'(r);
        x2   = mul_q60(x, x);
        term = x;
        sum  = x;
        for (int n = 3; n <= 29; n += 2)
        begin
            term = mul_q60(term, x2) / 64'((n - 1) * n);
            sum  = neg ? sum - term : sum + term;
            neg  = !neg;
        end
        sh = sum >> 44;
        return sh[16:0];
    endfunction

    function automatic sin_tab_t build_sin_tab();
        sin_tab_t t;
        for (int j = 0; j <= TAB_LAST; j++)
        begin
            t[j] = quarter_sine(j * TAB_STEP);
        end
        return t;
    endfunction

    localparam sin_tab_t SIN_TAB = build_sin_tab();

    // sine of angle k*8 table steps
    function automatic logic signed [MUL_B_W-1:0] sin_lookup(input logic [7:0] k);
        logic [16:0]              v;
        logic [6:0]               idx;
        logic signed [MUL_B_W-1:0] sv;
        idx = k[6] ? (7'(TAB_LAST) - {1'b0, k[5:0]}) : {1'b0, k[5:0]};
        v   = SIN_TAB[idx];
        sv  = signed'({1'b0, v});
        return k[7] ? -sv : sv;
    endfunction

endpackage

// ----- rtl/core/bgvt_div.sv -----
// iterative signed-by-unsigned divider, one quotient bit per cycle
// no package dependencies
module bgvt_div #(
    parameter int DW = 13
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [31:0]   dividend,
    input  logic [DW-1:0]        divisor,
    output logic                 done,
    output logic signed [31:0]   quotient
);

    logic          busy_reg;
    logic          done_reg;
    logic          neg_reg;
    logic [4:0]    cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [31:0]   quo_reg;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          ge;

    assign shifted = {rem_reg, quo_reg[31]};
    assign ge      = shifted >= {1'b0, divisor};
    assign diff    = shifted - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[31];
            rem_reg <= '0;
            quo_reg <= dividend[31] ? 32'(-dividend) : 32'(dividend);
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DW-1:0] : shifted[DW-1:0];
            quo_reg <= {quo_reg[30:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -signed'(quo_reg) : signed'(quo_reg);

endmodule

// ----- rtl/core/bgvt_mac.sv -----
// shared multiply-accumulate unit for rotation and scale
// depends on bgvt_pkg
module bgvt_mac (
    input  logic                                    clk,
    input  bgvt_pkg::mac_ctl_t                      ctl,
    input  logic signed [bgvt_pkg::MUL_A_W-1:0]     op_a,
    input  logic signed [bgvt_pkg::MUL_B_W-1:0]     op_b,
    output logic signed [bgvt_pkg::ACC_W-1:0]       acc
);

    logic signed [bgvt_pkg::ACC_W-1:0] acc_reg;
    logic signed [bgvt_pkg::ACC_W-1:0] prod;

    assign prod = bgvt_pkg::ACC_W'(op_a * op_b);

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            if (ctl.load)
                acc_reg <= prod;
            else if (ctl.sub)
                acc_reg <= acc_reg - prod;
            else
                acc_reg <= acc_reg + prod;
        end
    end

    assign acc = acc_reg;

endmodule

// ----- rtl/core/bone_group_vertex_transform.sv -----
// from accepting edge to out_valid: translate and alpha go straight to the output; scale runs
// a multiply and write-back per axis; rotate turns once per nonzero angle; accumulate gives no
// result; set origin loads args if group empty, else three serial divides, one bit per cycle
// throughput: one transaction at a time; the next is accepted the cycle after the result leaves
// reset: asynchronous active low; sums, count and origin cleared, block idle
// depends on bgvt_pkg, bgvt_div, bgvt_mac
module bone_group_vertex_transform #(
    parameter int MAX_GROUP_VERTICES = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         action,
    input  logic signed [15:0] vertex_x,
    input  logic signed [15:0] vertex_y,
    input  logic signed [15:0] vertex_z,
    input  logic [7:0]         face_alpha,
    input  logic signed [15:0] arg_one,
    input  logic signed [15:0] arg_two,
    input  logic signed [15:0] arg_three,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] new_x,
    output logic signed [15:0] new_y,
    output logic signed [15:0] new_z,
    output logic [7:0]         new_alpha
);

    localparam int CNT_W = $clog2(MAX_GROUP_VERTICES + 1);
    localparam int AW    = bgvt_pkg::MUL_A_W;
    localparam int BW    = bgvt_pkg::MUL_B_W;

    bgvt_pkg::state_t state_reg, state_next;

    logic signed [31:0] sum_reg [0:2];
    logic [CNT_W-1:0]   cnt_reg;
    logic signed [17:0] origin_reg [0:2];
    logic signed [15:0] arg_reg [0:2];
    logic signed [AW-1:0] dx_reg, dy_reg, dz_reg, na_reg;
    logic [1:0]         rot_reg;
    logic [2:0]         ph_reg;
    logic [1:0]         axis_reg;
    logic signed [15:0] res_reg [0:2];
    logic [7:0]         alpha_reg;

    logic               accept;
    logic               div_start, div_done;
    logic signed [31:0] div_q;
    bgvt_pkg::mac_ctl_t mac_ctl;
    logic signed [AW-1:0] mac_a, rot_a, rot_b, d_axis;
    logic signed [BW-1:0] mac_b, sin_v, cos_v;
    logic signed [bgvt_pkg::ACC_W-1:0] acc, acc_sh16, acc_rnd;
    logic [7:0]         ang;
    logic               plus_form;
    logic signed [AW-1:0] vx_e, vy_e, vz_e;
    logic signed [19:0] alpha_sum;

    assign accept   = in_valid && !in_stall;
    assign in_stall = state_reg != bgvt_pkg::ST_IDLE;

    assign vx_e = AW'(vertex_x);
    assign vy_e = AW'(vertex_y);
    assign vz_e = AW'(vertex_z);
    assign alpha_sum = 20'(signed'({1'b0, face_alpha})) + (20'(arg_one) <<< 3);

    // rotation pair and angle for the current stage: roll, pitch, yaw
    always_comb
    begin
        case (rot_reg)
            2'd0:
            begin
                rot_a = dx_reg; rot_b = dy_reg; ang = arg_reg[2][7:0]; plus_form = 1'b1;
            end
            2'd1:
            begin
                rot_a = dy_reg; rot_b = dz_reg; ang = arg_reg[0][7:0]; plus_form = 1'b0;
            end
            default:
            begin
                rot_a = dx_reg; rot_b = dz_reg; ang = arg_reg[1][7:0]; plus_form = 1'b1;
            end
        endcase
    end

    assign sin_v = bgvt_pkg::sin_lookup(ang);
    assign cos_v = bgvt_pkg::sin_lookup(ang + 8'd64);

    always_comb
    begin
        case (axis_reg)
            2'd0:    d_axis = dx_reg;
            2'd1:    d_axis = dy_reg;
            default: d_axis = dz_reg;
        endcase
    end

    assign acc_sh16 = acc >>> 16;
    assign acc_rnd  = (acc + (acc[bgvt_pkg::ACC_W-1] ? 39'sd127 : 39'sd0)) >>> 7;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        mac_ctl    = '0;
        mac_a      = rot_a;
        mac_b      = sin_v;
        case (state_reg)
            bgvt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        bgvt_pkg::ACT_SET_ORIGIN:
                            if (cnt_reg != '0)
                                state_next = bgvt_pkg::ST_DIV_START;
                        bgvt_pkg::ACT_TRANSLATE: state_next = bgvt_pkg::ST_OUT;
                        bgvt_pkg::ACT_ALPHA:     state_next = bgvt_pkg::ST_OUT;
                        bgvt_pkg::ACT_ROTATE:    state_next = bgvt_pkg::ST_ROT;
                        bgvt_pkg::ACT_SCALE:     state_next = bgvt_pkg::ST_SCALE;
                        default:                 state_next = bgvt_pkg::ST_IDLE;
                    endcase
                end
            end
            bgvt_pkg::ST_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = bgvt_pkg::ST_DIV_WAIT;
            end
            bgvt_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                    state_next = (axis_reg == 2'd2) ? bgvt_pkg::ST_IDLE
                                                    : bgvt_pkg::ST_DIV_START;
            end
            bgvt_pkg::ST_ROT:
            begin
                if (rot_reg == 2'd3)
                    state_next = bgvt_pkg::ST_OUT;
                else if (ang != 8'd0 && ph_reg <= 3'd3)
                begin
                    mac_ctl.en   = 1'b1;
                    mac_ctl.load = !ph_reg[0];
                    case (ph_reg[1:0])
                        2'd0:
                        begin
                            mac_a = plus_form ? rot_b : rot_a;
                            mac_b = plus_form ? sin_v : cos_v;
                        end
                        2'd1:
                        begin
                            mac_a       = plus_form ? rot_a : rot_b;
                            mac_b       = plus_form ? cos_v : sin_v;
                            mac_ctl.sub = !plus_form;
                        end
                        2'd2:
                        begin
                            mac_a = plus_form ? rot_b : rot_a;
                            mac_b = plus_form ? cos_v : sin_v;
                        end
                        default:
                        begin
                            mac_a       = plus_form ? rot_a : rot_b;
                            mac_b       = plus_form ? sin_v : cos_v;
                            mac_ctl.sub = plus_form;
                        end
                    endcase
                end
            end
            bgvt_pkg::ST_SCALE:
            begin
                mac_a = d_axis;
                mac_b = BW'(arg_reg[axis_reg]);
                if (ph_reg[0] == 1'b0)
                begin
                    mac_ctl.en   = 1'b1;
                    mac_ctl.load = 1'b1;
                end
                else if (axis_reg == 2'd2)
                    state_next = bgvt_pkg::ST_OUT;
            end
            bgvt_pkg::ST_OUT:
            begin
                if (!out_stall)
                    state_next = bgvt_pkg::ST_IDLE;
            end
            default: state_next = bgvt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bgvt_pkg::ST_IDLE;
            cnt_reg       <= '0;
            sum_reg[0]    <= '0;
            sum_reg[1]    <= '0;
            sum_reg[2]    <= '0;
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
            rot_reg       <= '0;
            ph_reg        <= '0;
            axis_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                bgvt_pkg::ST_IDLE:
                begin
                    rot_reg  <= '0;
                    ph_reg   <= '0;
                    axis_reg <= '0;
                    if (accept && action == bgvt_pkg::ACT_ACCUM
                        && cnt_reg < CNT_W'(MAX_GROUP_VERTICES))
                    begin
                        sum_reg[0] <= sum_reg[0] + 32'(vertex_x);
                        sum_reg[1] <= sum_reg[1] + 32'(vertex_y);
                        sum_reg[2] <= sum_reg[2] + 32'(vertex_z);
                        cnt_reg    <= cnt_reg + 1'b1;
                    end
                    if (accept && action == bgvt_pkg::ACT_SET_ORIGIN && cnt_reg == '0)
                    begin
                        origin_reg[0] <= 18'(arg_one);
                        origin_reg[1] <= 18'(arg_two);
                        origin_reg[2] <= 18'(arg_three);
                    end
                end
                bgvt_pkg::ST_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        origin_reg[axis_reg] <= 18'(32'(arg_reg[axis_reg]) + div_q);
                        axis_reg <= axis_reg + 2'd1;
                        if (axis_reg == 2'd2)
                        begin
                            sum_reg[0] <= '0;
                            sum_reg[1] <= '0;
                            sum_reg[2] <= '0;
                            cnt_reg    <= '0;
                        end
                    end
                end
                bgvt_pkg::ST_ROT:
                begin
                    if (rot_reg != 2'd3)
                    begin
                        if (ang == 8'd0 || ph_reg == 3'd4)
                        begin
                            ph_reg  <= '0;
                            rot_reg <= rot_reg + 2'd1;
                        end
                        else
                            ph_reg <= ph_reg + 3'd1;
                    end
                end
                bgvt_pkg::ST_SCALE:
                begin
                    ph_reg <= {2'b00, !ph_reg[0]};
                    if (ph_reg[0])
                        axis_reg <= axis_reg + 2'd1;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            arg_reg[0] <= arg_one;
            arg_reg[1] <= arg_two;
            arg_reg[2] <= arg_three;
            dx_reg <= vx_e - AW'(origin_reg[0]);
            dy_reg <= vy_e - AW'(origin_reg[1]);
            dz_reg <= vz_e - AW'(origin_reg[2]);
            if (action == bgvt_pkg::ACT_ALPHA)
            begin
                res_reg[0] <= '0;
                res_reg[1] <= '0;
                res_reg[2] <= '0;
                if (alpha_sum < 20'sd0)
                    alpha_reg <= 8'd0;
                else if (alpha_sum > 20'sd255)
                    alpha_reg <= 8'd255;
                else
                    alpha_reg <= alpha_sum[7:0];
            end
            else
            begin
                alpha_reg  <= 8'd0;
                res_reg[0] <= vertex_x + arg_one;
                res_reg[1] <= vertex_y + arg_two;
                res_reg[2] <= vertex_z + arg_three;
            end
        end
        else if (state_reg == bgvt_pkg::ST_ROT)
        begin
            if (rot_reg == 2'd3)
            begin
                res_reg[0] <= dx_reg[15:0] + origin_reg[0][15:0];
                res_reg[1] <= dy_reg[15:0] + origin_reg[1][15:0];
                res_reg[2] <= dz_reg[15:0] + origin_reg[2][15:0];
            end
            else if (ang != 8'd0 && ph_reg == 3'd2)
                na_reg <= acc_sh16[AW-1:0];
            else if (ang != 8'd0 && ph_reg == 3'd4)
            begin
                case (rot_reg)
                    2'd0:
                    begin
                        dx_reg <= na_reg; dy_reg <= acc_sh16[AW-1:0];
                    end
                    2'd1:
                    begin
                        dy_reg <= na_reg; dz_reg <= acc_sh16[AW-1:0];
                    end
                    default:
                    begin
                        dx_reg <= na_reg; dz_reg <= acc_sh16[AW-1:0];
                    end
                endcase
            end
        end
        else if (state_reg == bgvt_pkg::ST_SCALE && ph_reg[0])
            res_reg[axis_reg] <= acc_rnd[15:0] + origin_reg[axis_reg][15:0];
    end

    bgvt_div #(
        .DW (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg[axis_reg]),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    bgvt_mac u_mac (
        .clk  (clk),
        .ctl  (mac_ctl),
        .op_a (mac_a),
        .op_b (mac_b),
        .acc  (acc)
    );

    assign out_valid = state_reg == bgvt_pkg::ST_OUT;
    assign new_x     = res_reg[0];
    assign new_y     = res_reg[1];
    assign new_z     = res_reg[2];
    assign new_alpha = alpha_reg;

endmodule

// ----- rtl/core/bgvt_checker.sv -----
// port-level checks for the bone group vertex transform, bound to the top level
// depends on bgvt_pkg and bone_group_vertex_transform_defines.svh
`include "bone_group_vertex_transform_defines.svh"

module bgvt_port_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [2:0]         action,
    input logic signed [15:0] vertex_x,
    input logic signed [15:0] vertex_y,
    input logic signed [15:0] vertex_z,
    input logic [7:0]         face_alpha,
    input logic signed [15:0] arg_one,
    input logic signed [15:0] arg_two,
    input logic signed [15:0] arg_three,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] new_x,
    input logic signed [15:0] new_y,
    input logic signed [15:0] new_z,
    input logic [7:0]         new_alpha
);

    logic translate_take;
    logic alpha_out;
    logic coords_zero;

    assign translate_take = in_valid && !in_stall && action == bgvt_pkg::ACT_TRANSLATE;
    assign alpha_out      = out_valid && new_alpha != 8'd0;
    assign coords_zero    = new_x == 16'sd0 && new_y == 16'sd0 && new_z == 16'sd0;

    // a pending result keeps the input side closed
    `BGVT_ASSERT_IMP(a_busy_while_result, clk, rst_n, out_valid, in_stall)
    // stalled result stays offered
    `BGVT_ASSERT_NXT(a_result_held, clk, rst_n, out_valid && out_stall, out_valid)
    // translate transaction produces its result on the next cycle
    `BGVT_ASSERT_NXT(a_translate_fast, clk, rst_n, translate_take, out_valid)
    // alpha results carry no coordinates
    `BGVT_ASSERT_IMP(a_alpha_only, clk, rst_n, alpha_out, coords_zero)

endmodule

bind bone_group_vertex_transform bgvt_port_checker u_bgvt_port_checker (.*);
